[rtl/rlt_pkg.sv]
// Shared types, codes and helper functions of the request lifecycle tracker.
package rlt_pkg;

    // Default number of table slots.
    localparam int SLOTS_DEFAULT = 16;

    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes.
    localparam logic [1:0] OP_SUBMIT     = 2'd0;
    localparam logic [1:0] OP_LOOKUP     = 2'd1;
    localparam logic [1:0] OP_TRANSITION = 2'd2;
    localparam logic [1:0] OP_CANCEL     = 2'd3;

    // Lifecycle states.
    localparam logic [2:0] LC_SUBMITTED = 3'd0;
    localparam logic [2:0] LC_QUEUED    = 3'd1;
    localparam logic [2:0] LC_ACTIVE    = 3'd2;
    localparam logic [2:0] LC_COMPLETE  = 3'd3;
    localparam logic [2:0] LC_FAILED    = 3'd4;
    localparam logic [2:0] LC_CANCELED  = 3'd5;

    // Result status codes.
    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_FULL    = 3'd1;
    localparam logic [2:0] RC_NOENT   = 3'd2;
    localparam logic [2:0] RC_DENIED  = 3'd3;
    localparam logic [2:0] RC_ILLEGAL = 3'd4;

    // One stored table entry.
    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  lc_state;
        logic [3:0]  kind;
        logic [15:0] owner;
    } entry_t;

    // A classified command as it travels from front to back.
    typedef struct packed {
        logic        is_submit;
        logic        do_move;
        logic        check_owner;
        logic [2:0]  move_to;
        logic [31:0] request_id;
        logic [3:0]  request_kind;
        logic [15:0] owner_tag;
    } cmd_t;

    // Legal-move table of the lifecycle.
    function automatic logic move_allowed(input logic [2:0] from, input logic [2:0] to);
        logic ok;
        begin
            unique case (from)
                LC_SUBMITTED: ok = (to == LC_QUEUED) || (to == LC_CANCELED);
                LC_QUEUED:    ok = (to == LC_ACTIVE) || (to == LC_FAILED) || (to == LC_CANCELED);
                LC_ACTIVE:    ok = (to == LC_COMPLETE) || (to == LC_FAILED) || (to == LC_CANCELED);
                default:      ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    // True for states that no move leaves.
    function automatic logic ends_lifecycle(input logic [2:0] s);
        return (s == LC_COMPLETE) || (s == LC_FAILED) || (s == LC_CANCELED);
    endfunction

endpackage

[rtl/rlt_req_if.sv]
// Request channel interface: valid/ready handshake with the operation payload.
interface rlt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] request_id;
    logic [2:0]  target_state;
    logic [3:0]  request_kind;
    logic [15:0] owner_tag;
    logic        admin_bypass;

    modport source (
        output valid, opcode, request_id, target_state, request_kind, owner_tag, admin_bypass,
        input  ready
    );

    modport sink (
        input  valid, opcode, request_id, target_state, request_kind, owner_tag, admin_bypass,
        output ready
    );
endinterface

[rtl/rlt_rsp_if.sv]
// Response channel interface: valid/ready handshake with the result payload.
interface rlt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [2:0]  entry_state;
    logic [3:0]  entry_kind;
    logic [15:0] entry_owner;
    logic [4:0]  active_count;

    modport source (
        output valid, status, result_id, entry_state, entry_kind, entry_owner, active_count,
        input  ready
    );

    modport sink (
        input  valid, status, result_id, entry_state, entry_kind, entry_owner, active_count,
        output ready
    );
endinterface

[rtl/rlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rlt_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module rlt_front (
    input  logic           clk,
    input  logic           rst_n,
    rlt_req_if.sink        req,
    output logic           q_valid,
    output rlt_pkg::cmd_t  q_cmd,
    input  logic           q_pop
);

    localparam int QD = rlt_pkg::QUEUE_DEPTH;
    localparam int QW = (QD > 1) ? $clog2(QD) : 1;

    rlt_pkg::cmd_t  fifo_reg [QD];
    logic [QW-1:0]  wr_ptr_reg;
    logic [QW-1:0]  rd_ptr_reg;
    logic [QW:0]    count_reg;
    rlt_pkg::cmd_t  cmd_in;
    logic           push;
    logic           pop;

    // Classify the incoming operation.
    always_comb
    begin
        cmd_in.is_submit    = (req.opcode == rlt_pkg::OP_SUBMIT);
        cmd_in.do_move      = (req.opcode == rlt_pkg::OP_TRANSITION) ||
                              (req.opcode == rlt_pkg::OP_CANCEL);
        cmd_in.check_owner  = (req.opcode == rlt_pkg::OP_CANCEL) && !req.admin_bypass;
        cmd_in.move_to      = (req.opcode == rlt_pkg::OP_CANCEL) ? rlt_pkg::LC_CANCELED
                                                                 : req.target_state;
        cmd_in.request_id   = req.request_id;
        cmd_in.request_kind = req.request_kind;
        cmd_in.owner_tag    = req.owner_tag;
    end

    assign req.ready = (count_reg != (QW+1)'(QD));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_cmd     = fifo_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QW+1)'(1);
            end
        end
    end

endmodule

[rtl/rlt_back.sv]
// Back end: scans the slot table, applies the operation and registers the result.
module rlt_back #(
    parameter int SLOTS = rlt_pkg::SLOTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rlt_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    rlt_rsp_if.source      rsp
);

    localparam int IW     = $clog2(SLOTS);
    localparam int LIVE_W = $clog2(SLOTS + 1);
    localparam int ENT_W  = $bits(rlt_pkg::entry_t);
    localparam logic [IW:0] SCAN_END = (IW+1)'(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FREE = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]          state_reg, state_next;
    rlt_pkg::cmd_t       cmd_reg, cmd_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [31:0]         next_id_reg, next_id_next;
    logic [LIVE_W-1:0]   live_reg, live_next;
    logic [IW:0]         scan_reg, scan_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    rlt_pkg::entry_t     entry_reg, entry_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          status_reg;
    rlt_pkg::entry_t     res_reg;
    logic [4:0]          active_reg;

    logic [ENT_W-1:0]    ram_rdata;
    rlt_pkg::entry_t     rd_entry;
    logic                ram_we;

    logic [2:0]          ex_status;
    rlt_pkg::entry_t     ex_res;
    logic                ex_write;
    logic [LIVE_W-1:0]   ex_live;
    logic [LIVE_W+4:0]   ex_live_wide;
    logic [4:0]          ex_active;
    logic                commit;

    // Entry storage: id, state, kind and owner of every slot.
    rlt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (hit_idx_reg),
        .wr_data (ENT_W'(ex_res)),
        .rd_addr (scan_reg[IW-1:0]),
        .rd_data (ram_rdata)
    );

    assign rd_entry = rlt_pkg::entry_t'(ram_rdata);

    // Outcome of the operation once the scan has settled on a slot or none.
    always_comb
    begin
        ex_status = rlt_pkg::RC_OK;
        ex_res    = entry_reg;
        ex_write  = 1'b0;
        ex_live   = live_reg;
        if (cmd_reg.is_submit)
        begin
            if (hit_reg)
            begin
                ex_res.id       = next_id_reg;
                ex_res.lc_state = rlt_pkg::LC_SUBMITTED;
                ex_res.kind     = cmd_reg.request_kind;
                ex_res.owner    = cmd_reg.owner_tag;
                ex_write        = 1'b1;
                ex_live         = live_reg + LIVE_W'(1);
            end
            else
            begin
                ex_status = rlt_pkg::RC_FULL;
                ex_res    = '0;
            end
        end
        else if (!hit_reg)
        begin
            ex_status = rlt_pkg::RC_NOENT;
            ex_res    = '0;
            ex_res.id = cmd_reg.request_id;
        end
        else if (cmd_reg.do_move)
        begin
            if (cmd_reg.check_owner && (entry_reg.owner != cmd_reg.owner_tag))
            begin
                ex_status = rlt_pkg::RC_DENIED;
            end
            else if (!rlt_pkg::move_allowed(entry_reg.lc_state, cmd_reg.move_to))
            begin
                ex_status = rlt_pkg::RC_ILLEGAL;
            end
            else
            begin
                ex_res.lc_state = cmd_reg.move_to;
                ex_write        = 1'b1;
                if (rlt_pkg::ends_lifecycle(cmd_reg.move_to) && (live_reg != '0))
                begin
                    ex_live = live_reg - LIVE_W'(1);
                end
            end
        end
    end

    // Reported count saturates at the field's maximum.
    assign ex_live_wide = {5'd0, ex_live};
    assign ex_active    = (ex_live_wide > (LIVE_W+5)'(31)) ? 5'd31 : ex_live_wide[4:0];

    assign commit = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign ram_we = commit && ex_write;

    // Sequencer: take a command, scan for a slot, then commit the result.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        next_id_next   = next_id_reg;
        live_next      = live_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        entry_next     = entry_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cmd_next       = q_cmd;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = q_cmd.is_submit ? S_FREE : S_FIND;
                end
            end
            S_FREE:
            begin
                // One used bit per cycle, lowest slot first.
                if (scan_reg == SCAN_END)
                begin
                    hit_next   = 1'b0;
                    state_next = S_EXEC;
                end
                else if (!used_reg[scan_reg[IW-1:0]])
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_reg[IW-1:0];
                    state_next   = S_EXEC;
                end
                else
                begin
                    scan_next = scan_reg + (IW+1)'(1);
                end
            end
            S_FIND:
            begin
                // Read one slot per cycle; compare the slot read in the cycle before.
                if (cmp_valid_reg && used_reg[cmp_idx_reg] &&
                    (rd_entry.id == cmd_reg.request_id))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    entry_next   = rd_entry;
                    state_next   = S_EXEC;
                end
                else if (scan_reg == SCAN_END)
                begin
                    hit_next   = 1'b0;
                    state_next = S_EXEC;
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IW-1:0];
                    scan_next      = scan_reg + (IW+1)'(1);
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    live_next      = ex_live;
                    if (cmd_reg.is_submit && hit_reg)
                    begin
                        used_next[hit_idx_reg] = 1'b1;
                        next_id_next           = next_id_reg + 32'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            next_id_reg   <= 32'd1;
            live_reg      <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            next_id_reg   <= next_id_next;
            live_reg      <= live_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: command, scan position, captured entry and result.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        entry_reg   <= entry_next;
        if (commit)
        begin
            status_reg <= ex_status;
            res_reg    <= ex_res;
            active_reg <= ex_active;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.result_id    = res_reg.id;
    assign rsp.entry_state  = res_reg.lc_state;
    assign rsp.entry_kind   = res_reg.kind;
    assign rsp.entry_owner  = res_reg.owner;
    assign rsp.active_count = active_reg;

endmodule

[rtl/request_lifecycle_tracker.sv]
// Top level of the request lifecycle tracker: front end, command queue and back end.
//
//   channel | modport | transfer carries
//   --------+---------+---------------------------------------------------------------
//   req     | sink    | opcode, request_id, target_state, request_kind, owner_tag, admin_bypass
//   rsp     | source  | status, result_id, entry_state, entry_kind, entry_owner, active_count
//
// Each operation is one scan of the slot table, one slot per cycle: a submit scans the used
// bits for the first free slot, a lookup, move or cancel reads the entries for a matching
// id, and the scan ends after the last slot when nothing matches. The single table read
// port sets that pace. Reset clears the used bits, the live count and sets the next id to
// one; entry contents need no clearing. A two-entry queue lets requests be taken while the
// back end works, and a registered result waits for rsp.ready without losing data.
module request_lifecycle_tracker #(
    parameter int SLOTS = rlt_pkg::SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    rlt_req_if.sink    req,
    rlt_rsp_if.source  rsp
);

    logic           q_valid;
    logic           q_pop;
    rlt_pkg::cmd_t  q_cmd;

    // Accept and classify requests.
    rlt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // Carry out operations against the slot table.
    rlt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
